FILE: hw/rtl/ptr_pkg.sv
`default_nettype none
// ============================================================================
// ptr_pkg
// Shared types, register indexes and arithmetic helpers for the pixel
// tolerance recolor block.
// ============================================================================
package ptr_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] REG_PRIMARY   = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_SECONDARY = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_SWAP      = 2'd2;
  localparam logic [CfgIndexWidth-1:0] REG_TOLERANCE = 2'd3;

  localparam int unsigned CfgDataWidth = 24;

  // Register reset values.
  localparam logic [23:0] PRIMARY_RESET   = 24'h000000;
  localparam logic [23:0] SECONDARY_RESET = 24'hFFFFFF;
  localparam logic [6:0]  TOLERANCE_RESET = 7'd50;

  // percent*256/100 = (percent*5243) >> 11, exact for percent below 128.
  localparam logic [12:0] PCT_RECIP       = 13'd5243;
  localparam int unsigned PCT_RECIP_SHIFT = 11;

  // Input item.
  typedef struct packed {
    logic [7:0] pixel_blue;
    logic [7:0] pixel_green;
    logic [7:0] pixel_red;
    logic [7:0] pixel_alpha;
    logic [7:0] coverage;
    logic       in_selection;
  } pixel_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       recolored;
  } result_t;

  // Threshold sequencer states.
  typedef enum logic [2:0] {
    RC_DIST,
    RC_ROOT,
    RC_MIN,
    RC_THR,
    RC_READY
  } rc_state_t;

  // Absolute difference of two channel values.
  function automatic logic [7:0] abs_diff8(input logic [7:0] a, input logic [7:0] b);
    abs_diff8 = (a > b) ? (a - b) : (b - a);
  endfunction

  // Channel shifted by (target - source), clamped to 0..255.
  function automatic logic [7:0] shift_clamp(input logic [7:0] p, input logic [7:0] s,
                                             input logic [7:0] t);
    logic signed [9:0] v;
    v = $signed({2'b00, p}) + $signed({2'b00, t}) - $signed({2'b00, s});
    if (v < 10'sd0) begin
      shift_clamp = 8'd0;
    end else if (v > 10'sd255) begin
      shift_clamp = 8'd255;
    end else begin
      shift_clamp = v[7:0];
    end
  endfunction

  // Truncating division by 255, exact for values up to 65025.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    div255 = sum[15:8];
  endfunction

endpackage : ptr_pkg
`default_nettype wire

FILE: hw/rtl/pixel_tolerance_recolor.sv
`default_nettype none
// ============================================================================
// pixel_tolerance_recolor
// Tolerance-matched color replacement with coverage blend for one pixel.
// ============================================================================
//
// Channel    Signals                         Direction  Notes
// ---------  ------------------------------  ---------  ------------------------
// pixel in   start, busy, pixel_in           in         taken on start && !busy
// result     done, result                    out        one cycle, no back-pressure
// config     cfg_we, cfg_index, cfg_data     in         written on cfg_we
//
// One item may enter every cycle while busy is low. The match threshold
// 3*tol^2 is computed by a bit-serial square-root sequencer: after reset and
// after every configuration write, busy stays high through distance, 8 root
// steps, clamp and square. Reset is synchronous; it clears the pipeline
// valid bits and sets the configuration registers to their reset values.
// The result side cannot stall, so the pipeline never holds.
module pixel_tolerance_recolor
  import ptr_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire pixel_t                   pixel_in,
  output logic                          done,
  output result_t                       result,
  input  wire logic                     cfg_we,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_data
);

  // Configuration registers.
  logic [23:0] primary_color;
  logic [23:0] secondary_color;
  logic        swap_mode;
  logic [6:0]  tolerance_percent;

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_color     <= PRIMARY_RESET;
      secondary_color   <= SECONDARY_RESET;
      swap_mode         <= 1'b0;
      tolerance_percent <= TOLERANCE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PRIMARY:   primary_color     <= cfg_data[23:0];
        REG_SECONDARY: secondary_color   <= cfg_data[23:0];
        REG_SWAP:      swap_mode         <= cfg_data[0];
        REG_TOLERANCE: tolerance_percent <= cfg_data[6:0];
        default:       ;
      endcase
    end
  end

  // Source and target colors chosen by the swap mode.
  logic [23:0] src_color;
  logic [23:0] dst_color;
  logic [7:0]  src_b, src_g, src_r;
  logic [7:0]  dst_b, dst_g, dst_r;

  assign src_color = swap_mode ? primary_color : secondary_color;
  assign dst_color = swap_mode ? secondary_color : primary_color;
  assign src_b = src_color[7:0];
  assign src_g = src_color[15:8];
  assign src_r = src_color[23:16];
  assign dst_b = dst_color[7:0];
  assign dst_g = dst_color[15:8];
  assign dst_r = dst_color[23:16];

  // --------------------------------------------------------------------------
  // Threshold sequencer.
  // --------------------------------------------------------------------------
  rc_state_t   state;
  rc_state_t   state_next;
  logic [17:0] color_dist;
  logic [7:0]  root;
  logic [2:0]  root_bit;
  logic [7:0]  tol;
  logic [17:0] threshold;

  // Source-to-target squared distance.
  logic [7:0]  cd_b, cd_g, cd_r;
  logic [17:0] color_dist_calc;

  assign cd_b = abs_diff8(src_b, dst_b);
  assign cd_g = abs_diff8(src_g, dst_g);
  assign cd_r = abs_diff8(src_r, dst_r);
  assign color_dist_calc = {2'b00, {8'd0, cd_b} * {8'd0, cd_b}}
                         + {2'b00, {8'd0, cd_g} * {8'd0, cd_g}}
                         + {2'b00, {8'd0, cd_r} * {8'd0, cd_r}};

  // One root bit per step: keep it while 3*cand^2 stays below the distance.
  logic [7:0]  cand;
  logic [15:0] cand_sq;
  logic [17:0] cand_sq3;

  assign cand     = root | (8'd1 << root_bit);
  assign cand_sq  = {8'd0, cand} * {8'd0, cand};
  assign cand_sq3 = {1'b0, cand_sq, 1'b0} + {2'b00, cand_sq};

  // Smallest m with 3m^2 >= distance, and the scaled percent.
  logic [7:0]  root_min;
  logic [19:0] pct_prod;
  logic [8:0]  pct_scaled;
  logic [15:0] tol_sq;

  assign root_min   = (color_dist == 18'd0) ? 8'd0 : (root + 8'd1);
  assign pct_prod   = {13'd0, tolerance_percent} * {7'd0, PCT_RECIP};
  assign pct_scaled = pct_prod[PCT_RECIP_SHIFT +: 9];
  assign tol_sq     = {8'd0, tol} * {8'd0, tol};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      RC_DIST:  state_next = RC_ROOT;
      RC_ROOT:  state_next = (root_bit == 3'd0) ? RC_MIN : RC_ROOT;
      RC_MIN:   state_next = RC_THR;
      RC_THR:   state_next = RC_READY;
      RC_READY: state_next = RC_READY;
      default:  state_next = RC_DIST;
    endcase
    if (cfg_we) begin
      state_next = RC_DIST;
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    case (state)
      RC_READY: busy = 1'b0;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RC_DIST;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    case (state)
      RC_DIST: begin
        color_dist <= color_dist_calc;
        root       <= 8'd0;
        root_bit   <= 3'd7;
      end
      RC_ROOT: begin
        if (cand_sq3 < color_dist) begin
          root <= cand;
        end
        root_bit <= root_bit - 3'd1;
      end
      RC_MIN: begin
        tol <= (pct_scaled < {1'b0, root_min}) ? pct_scaled[7:0] : root_min;
      end
      RC_THR: begin
        threshold <= {1'b0, tol_sq, 1'b0} + {2'b00, tol_sq};
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pixel pipeline.
  // --------------------------------------------------------------------------
  logic accept;
  assign accept = start && !busy;

  // Stage 1: distances to the source and shifted channels.
  logic       v1;
  logic [7:0] p1_b, p1_g, p1_r, alpha1, cov1;
  logic       sel1;
  logic [7:0] pd1_b, pd1_g, pd1_r;
  logic [7:0] sh1_b, sh1_g, sh1_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    p1_b   <= pixel_in.pixel_blue;
    p1_g   <= pixel_in.pixel_green;
    p1_r   <= pixel_in.pixel_red;
    alpha1 <= pixel_in.pixel_alpha;
    cov1   <= pixel_in.coverage;
    sel1   <= pixel_in.in_selection;
    pd1_b  <= abs_diff8(pixel_in.pixel_blue, src_b);
    pd1_g  <= abs_diff8(pixel_in.pixel_green, src_g);
    pd1_r  <= abs_diff8(pixel_in.pixel_red, src_r);
    sh1_b  <= shift_clamp(pixel_in.pixel_blue, src_b, dst_b);
    sh1_g  <= shift_clamp(pixel_in.pixel_green, src_g, dst_g);
    sh1_r  <= shift_clamp(pixel_in.pixel_red, src_r, dst_r);
  end

  // Stage 2: squared distance and blend numerators.
  logic        v2;
  logic [7:0]  p2_b, p2_g, p2_r, alpha2;
  logic        gate2;
  logic [17:0] pix_dist2;
  logic [15:0] num2_b, num2_g, num2_r;
  logic [7:0]  cov1_inv;

  assign cov1_inv = 8'd255 - cov1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    p2_b      <= p1_b;
    p2_g      <= p1_g;
    p2_r      <= p1_r;
    alpha2    <= alpha1;
    gate2     <= (cov1 != 8'd0) && sel1;
    pix_dist2 <= {2'b00, {8'd0, pd1_b} * {8'd0, pd1_b}}
               + {2'b00, {8'd0, pd1_g} * {8'd0, pd1_g}}
               + {2'b00, {8'd0, pd1_r} * {8'd0, pd1_r}};
    num2_b    <= ({8'd0, sh1_b} * {8'd0, cov1}) + ({8'd0, p1_b} * {8'd0, cov1_inv});
    num2_g    <= ({8'd0, sh1_g} * {8'd0, cov1}) + ({8'd0, p1_g} * {8'd0, cov1_inv});
    num2_r    <= ({8'd0, sh1_r} * {8'd0, cov1}) + ({8'd0, p1_r} * {8'd0, cov1_inv});
  end

  // Stage 3: match decision, divide by 255 and output register.
  logic hit;
  assign hit = gate2 && (pix_dist2 <= threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    result.out_blue  <= hit ? div255(num2_b) : p2_b;
    result.out_green <= hit ? div255(num2_g) : p2_g;
    result.out_red   <= hit ? div255(num2_r) : p2_r;
    result.out_alpha <= alpha2;
    result.recolored <= hit;
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result without an item accepted three cycles earlier");

  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy)
    else $error("threshold not recomputed after a configuration write");

  a_alpha_pass: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.out_alpha == $past(pixel_in.pixel_alpha, 3)))
    else $error("alpha changed on its way through");

  a_hit_gate: assert property (@(posedge clk) disable iff (rst)
    (done && result.recolored) |->
      $past((pixel_in.coverage != 8'd0) && pixel_in.in_selection, 3))
    else $error("pixel recolored without coverage or selection");

  a_miss_keep: assert property (@(posedge clk) disable iff (rst)
    (done && !result.recolored) |->
      (result.out_blue == $past(pixel_in.pixel_blue, 3)) &&
      (result.out_red == $past(pixel_in.pixel_red, 3)))
    else $error("unmatched pixel was modified");

endmodule : pixel_tolerance_recolor
`default_nettype wire
